@@ rtl/sha1md_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types, constants and command/status structs for the SHA-1 digest.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    localparam int COUNT_W  = 61;
    localparam int ROUNDS   = 80;
    localparam int BLK_BYTES = 64;
    localparam int LEN_POS  = 56;
    localparam int DIGEST_WORDS = 5;

    typedef logic [31:0] t_word;

    localparam t_word INIT_H0 = 32'h67452301;
    localparam t_word INIT_H1 = 32'hEFCDAB89;
    localparam t_word INIT_H2 = 32'h98BADCFE;
    localparam t_word INIT_H3 = 32'h10325476;
    localparam t_word INIT_H4 = 32'hC3D2E1F0;

    localparam t_word K_CH  = 32'h5A827999;
    localparam t_word K_PAR = 32'h6ED9EBA1;
    localparam t_word K_MAJ = 32'h8F1BBCDC;
    localparam t_word K_PAR2 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // request codes
    localparam logic REQ_DATA   = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    // byte source for the block shift register
    typedef logic [1:0] t_bsel;
    localparam t_bsel BSEL_DATA = 2'd0;
    localparam t_bsel BSEL_PAD  = 2'd1;
    localparam t_bsel BSEL_ZERO = 2'd2;
    localparam t_bsel BSEL_LEN  = 2'd3;

    // round function group
    typedef logic [1:0] t_phase;
    localparam t_phase PH_CH   = 2'd0;
    localparam t_phase PH_PAR  = 2'd1;
    localparam t_phase PH_MAJ  = 2'd2;
    localparam t_phase PH_PAR2 = 2'd3;

    typedef struct packed {
        logic    shift;
        t_bsel   bsel;
        logic    count_inc;
        logic    count_clr;
        logic    round_init;
        logic    round_en;
        t_phase  phase;
        logic    chain_add;
        logic    chain_init;
        logic    out_load;
        logic [2:0] out_idx;
    } t_cmd;

    typedef struct packed {
        logic [5:0] pos;
        logic       out_free;
    } t_stat;

    function automatic t_word rotl(input t_word x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

endpackage

@@ rtl/sha1md_datapath.sv @@
// ----------------------------------------------------------------------------
// sha1md_datapath
// Block/schedule shift register, round unit, chaining words, byte counter
// and the output register.
// ----------------------------------------------------------------------------
module sha1md_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha1md_pkg::t_cmd   i_cmd,
    input  logic [7:0]         i_data_byte,
    input  logic               i_out_stall,
    output sha1md_pkg::t_stat  o_stat,
    output logic               o_out_valid,
    output logic [31:0]        o_digest_word,
    output logic [2:0]         o_word_index,
    output logic               o_last_word
);
    import sha1md_pkg::*;

    logic [COUNT_W-1:0] r_count;
    logic [5:0]         r_pos;
    logic [511:0]       r_sched;
    t_word              r_a, r_b, r_c, r_d, r_e;
    t_word              r_chain [DIGEST_WORDS];
    logic               r_out_valid;
    t_word              r_out_word;
    logic [2:0]         r_out_idx;
    logic               r_out_last;

    logic [7:0]         byte_in;
    logic [7:0][7:0]    len_bytes;
    t_word              w0, w2, w8, w13, w_new;
    t_word              f, k, tmp;
    logic               out_free;

    // message length in bits, big-endian bytes
    assign len_bytes = {r_count, 3'b000};

    always_comb begin
        unique case (i_cmd.bsel)
            BSEL_DATA: byte_in = i_data_byte;
            BSEL_PAD:  byte_in = PAD_BYTE;
            BSEL_ZERO: byte_in = 8'h00;
            BSEL_LEN:  byte_in = len_bytes[3'd7 - r_pos[2:0]];
            default:   byte_in = 8'h00;
        endcase
    end

    // window holds W[t..t+15], oldest word in the top bits
    assign w0    = r_sched[511:480];
    assign w2    = r_sched[447:416];
    assign w8    = r_sched[255:224];
    assign w13   = r_sched[95:64];
    assign w_new = rotl(w13 ^ w8 ^ w2 ^ w0, 1);

    always_comb begin
        unique case (i_cmd.phase)
            PH_CH: begin
                f = r_d ^ (r_b & (r_c ^ r_d));
                k = K_CH;
            end
            PH_PAR: begin
                f = r_b ^ r_c ^ r_d;
                k = K_PAR;
            end
            PH_MAJ: begin
                f = (r_b & r_c) | (r_d & (r_b | r_c));
                k = K_MAJ;
            end
            PH_PAR2: begin
                f = r_b ^ r_c ^ r_d;
                k = K_PAR2;
            end
            default: begin
                f = r_b ^ r_c ^ r_d;
                k = K_PAR2;
            end
        endcase
    end

    assign tmp = rotl(r_a, 5) + f + r_e + k + w0;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cmd.count_clr) begin
                r_count <= '0;
                r_pos   <= '0;
            end else begin
                if (i_cmd.count_inc) r_count <= r_count + 1'b1;
                if (i_cmd.shift)     r_pos   <= r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_sched <= {r_sched[503:0], byte_in};
        end else if (i_cmd.round_en) begin
            r_sched <= {r_sched[479:0], w_new};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.round_init) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (i_cmd.round_en) begin
            r_a <= tmp;
            r_b <= r_a;
            r_c <= rotl(r_b, 30);
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.chain_init) begin
            r_chain[0] <= INIT_H0;
            r_chain[1] <= INIT_H1;
            r_chain[2] <= INIT_H2;
            r_chain[3] <= INIT_H3;
            r_chain[4] <= INIT_H4;
        end else if (i_cmd.chain_add) begin
            r_chain[0] <= r_chain[0] + r_a;
            r_chain[1] <= r_chain[1] + r_b;
            r_chain[2] <= r_chain[2] + r_c;
            r_chain[3] <= r_chain[3] + r_d;
            r_chain[4] <= r_chain[4] + r_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_word <= r_chain[i_cmd.out_idx];
            r_out_idx  <= i_cmd.out_idx;
            r_out_last <= (i_cmd.out_idx == 3'(DIGEST_WORDS - 1));
        end
    end

    assign o_stat.pos      = r_pos;
    assign o_stat.out_free = out_free;
    assign o_out_valid     = r_out_valid;
    assign o_digest_word   = r_out_word;
    assign o_word_index    = r_out_idx;
    assign o_last_word     = r_out_last;

endmodule

@@ rtl/sha1md_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha1md_ctrl
// Sequencer: byte intake, padding, 80-round compression, digest readout.
// ----------------------------------------------------------------------------
module sha1md_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_req_type,
    input  sha1md_pkg::t_stat  i_stat,
    output logic               o_in_stall,
    output sha1md_pkg::t_cmd   o_cmd
);
    import sha1md_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [5:0] POS_LAST = 6'(BLK_BYTES - 1);
    localparam logic [5:0] POS_LEN  = 6'(LEN_POS);

    logic [2:0] r_state, n_state;
    logic [6:0] r_round, n_round;
    logic [2:0] r_idx,   n_idx;
    logic       r_first, n_first;
    logic       r_spill, n_spill;
    logic       r_last,  n_last;
    logic       r_fin,   n_fin;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_round = r_round;
        n_idx   = r_idx;
        n_first = r_first;
        n_spill = r_spill;
        n_last  = r_last;
        n_fin   = r_fin;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == REQ_FINISH) begin
                        n_fin   = 1'b1;
                        n_first = 1'b1;
                        n_spill = 1'b0;
                        n_state = S_PAD;
                    end else begin
                        o_cmd.shift     = 1'b1;
                        o_cmd.bsel      = BSEL_DATA;
                        o_cmd.count_inc = 1'b1;
                        if (i_stat.pos == POS_LAST) begin
                            o_cmd.round_init = 1'b1;
                            n_round = '0;
                            n_last  = 1'b0;
                            n_state = S_ROUND;
                        end
                    end
                end
            end
            S_PAD: begin
                o_cmd.shift = 1'b1;
                if (r_first) begin
                    o_cmd.bsel = BSEL_PAD;
                    n_first = 1'b0;
                    // pad byte lands where the length should go: extra block
                    n_spill = (i_stat.pos >= POS_LEN);
                end else if (r_spill || (i_stat.pos < POS_LEN)) begin
                    o_cmd.bsel = BSEL_ZERO;
                end else begin
                    o_cmd.bsel = BSEL_LEN;
                end
                if (i_stat.pos == POS_LAST) begin
                    o_cmd.round_init = 1'b1;
                    n_round = '0;
                    n_last  = !(r_first || r_spill);
                    n_spill = 1'b0;
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                if (r_round < 7'd20) begin
                    o_cmd.phase = PH_CH;
                end else if (r_round < 7'd40) begin
                    o_cmd.phase = PH_PAR;
                end else if (r_round < 7'd60) begin
                    o_cmd.phase = PH_MAJ;
                end else begin
                    o_cmd.phase = PH_PAR2;
                end
                n_round = r_round + 1'b1;
                if (r_round == 7'(ROUNDS - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.chain_add = 1'b1;
                if (r_last) begin
                    n_idx   = '0;
                    n_fin   = 1'b0;
                    n_state = S_OUT;
                end else if (r_fin) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_idx  = r_idx;
                    if (r_idx == 3'(DIGEST_WORDS - 1)) begin
                        o_cmd.chain_init = 1'b1;
                        o_cmd.count_clr  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
            r_idx   <= '0;
            r_first <= 1'b0;
            r_spill <= 1'b0;
            r_last  <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_idx   <= n_idx;
            r_first <= n_first;
            r_spill <= n_spill;
            r_last  <= n_last;
            r_fin   <= n_fin;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ rtl/sha1_message_digest.sv @@
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 hash over a byte stream; five-word digest out per finished message.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_stall): each transfer carries either a
//    message byte (i_req_type = 0) or a finish request (i_req_type = 1).
//  - Output channel (o_out_valid / i_out_stall): a finish yields five
//    transfers, digest words 0..4 most significant first; o_last_word marks
//    word 4.
//  - Throughput: one byte per cycle while the input is not stalled; every 64th
//    byte stalls the input for the 80 rounds on the single round unit and
//    then the chaining add.
//  - Finish: one pad/length byte per cycle up to the block end, the 80 rounds
//    and the chaining add, the same for a second block when the tail spills,
//    then the five words, one per cycle while the receiver does not stall.
//  - Reset (synchronous, active low) loads the initial chaining words and
//    clears the byte count; no result is pending afterwards.
//  - A stalling receiver holds the current word in the output register; the
//    sequencer waits, and the input stays stalled until word 4 is loaded.
// ----------------------------------------------------------------------------
module sha1_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha1md_pkg::*;

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    sha1md_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    sha1md_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_data_byte),
        .i_out_stall   (i_out_stall),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sha1_message_digest. Byte and finish transfers are
// queued up front, driven with random gaps but for the last third, and each
// accepted one feeds a bit-accurate SHA-1 model queueing the five digest words.
// ----------------------------------------------------------------------------
module tb_top;
    import sha1md_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before giving up
    localparam int HOLD_CYCLES    = 500;   // long receiver hold-off
    localparam int DRAIN_CYCLES   = 300;   // covers a two-block finish
    localparam int MIN_ITEMS      = 210;
    localparam int MIN_MESSAGES   = 8;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        logic       req;
        logic [7:0] data;
    } t_byte_req;

    typedef struct packed {
        t_word      word;
        logic [2:0] idx;
        logic       last;
    } t_digest_exp;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_req_type  = REQ_DATA;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha1_message_digest u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Hash model state: chaining words, running byte count, current block
    // ------------------------------------------------------------------------
    t_word              hash_words [DIGEST_WORDS];
    logic [COUNT_W-1:0] msg_len;
    logic [7:0]         blk_buf [BLK_BYTES];

    t_byte_req   byte_stream_q [$];   // transfers still to be offered
    t_digest_exp digest_q [$];        // digest words still to arrive

    // lengths around the pad and length-field boundaries; 56..63 and 120..127
    // spill the padding into a second block, 64 and 128 finish on a block edge
    int tail_lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    int unsigned n_items_total = 0;
    int unsigned n_in_done     = 0;
    int unsigned n_faults      = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned hold_left     = 0;
    logic        hold_done     = 1'b0;
    logic        in_fire       = 1'b0;  // input transfer at the last rising edge

    function automatic void restart_hash();
        hash_words[0] = INIT_H0;
        hash_words[1] = INIT_H1;
        hash_words[2] = INIT_H2;
        hash_words[3] = INIT_H3;
        hash_words[4] = INIT_H4;
        msg_len = '0;
    endfunction

    // 80 rounds over blk_buf with a 16-word rolling schedule
    function automatic void sha1_compress();
        t_word w [16];
        t_word a, b, c, d, e, f, k, x, sum;
        int    t;
        for (t = 0; t < 16; t++)
            w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
        a = hash_words[0];
        b = hash_words[1];
        c = hash_words[2];
        d = hash_words[3];
        e = hash_words[4];
        for (t = 0; t < ROUNDS; t++) begin
            if (t < 16) begin
                x = w[t];
            end else begin
                x = w[(t-3) & 15] ^ w[(t-8) & 15] ^ w[(t-14) & 15] ^ w[t & 15];
                x = {x[30:0], x[31]};
                w[t & 15] = x;
            end
            if (t < 20) begin
                f = d ^ (b & (c ^ d));
                k = K_CH;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_PAR;
            end else if (t < 60) begin
                f = (b & c) | (d & (b | c));
                k = K_MAJ;
            end else begin
                f = b ^ c ^ d;
                k = K_PAR2;
            end
            sum = {a[26:0], a[31:27]} + f + e + k + x;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = sum;
        end
        hash_words[0] += a;
        hash_words[1] += b;
        hash_words[2] += c;
        hash_words[3] += d;
        hash_words[4] += e;
    endfunction

    function automatic void absorb_byte(input logic [7:0] v);
        logic [5:0] pos;
        pos = msg_len[5:0];
        blk_buf[pos] = v;
        msg_len = msg_len + 1'b1;
        if (pos == 6'd63)
            sha1_compress();
    endfunction

    // pad, append the bit length, compress, queue the digest words and restart
    function automatic void close_message();
        logic [63:0] bit_len;
        int          p;
        int          i;
        bit_len = {msg_len, 3'b000};
        p = msg_len[5:0];
        blk_buf[p] = PAD_BYTE;
        p++;
        if (p > LEN_POS) begin
            while (p < BLK_BYTES) begin
                blk_buf[p] = 8'h00;
                p++;
            end
            sha1_compress();
            p = 0;
        end
        while (p < LEN_POS) begin
            blk_buf[p] = 8'h00;
            p++;
        end
        for (i = 0; i < 8; i++)
            blk_buf[LEN_POS + i] = bit_len[63 - 8*i -: 8];
        sha1_compress();
        for (i = 0; i < DIGEST_WORDS; i++)
            digest_q.push_back('{hash_words[i], 3'(i), i == DIGEST_WORDS - 1});
        restart_hash();
    endfunction

    function automatic void push_item(input logic req, input logic [7:0] data);
        byte_stream_q.push_back('{req, data});
    endfunction

    // random content; the byte offered with the finish is junk and ignored
    function automatic void push_message(input int len);
        int n;
        for (n = 0; n < len; n++)
            push_item(REQ_DATA, 8'($urandom_range(0, 255)));
        push_item(REQ_FINISH, 8'($urandom_range(0, 255)));
    endfunction

    // Gap mix by progress: sender light / receiver heavy, then swapped,
    // then a final third with no random gaps at all.
    function automatic int unsigned idle_pct(input logic receiver);
        int unsigned phase;
        phase = (n_items_total == 0) ? 0 : (n_in_done * 3) / n_items_total;
        case (phase)
            0:       idle_pct = receiver ? 72 : 24;
            1:       idle_pct = receiver ? 24 : 72;
            default: idle_pct = 0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver: changes on the falling edge; a stalled transfer is held intact
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !in_fire)) begin
            if (byte_stream_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
                i_in_valid  <= 1'b1;
                i_req_type  <= byte_stream_q[0].req;
                i_data_byte <= byte_stream_q[0].data;
            end else begin
                i_in_valid  <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall, plus one long hold-off at the start of the
    // gap-free third so the digest words back up and the input stalls
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && idle_pct(1'b1) == 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            hold_done   <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: samples on the rising edge. Digest words are checked against
    // the oldest expectation before any new finish is modelled.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_digest_exp exp_w;
        logic        in_ok;
        logic        out_ok;
        in_ok   = i_rst_n && i_in_valid && !o_in_stall;
        out_ok  = i_rst_n && o_out_valid && !i_out_stall;
        in_fire <= in_ok;
        if (out_ok) begin
            if (digest_q.size() == 0) begin
                n_faults++;
                if (n_faults <= REPORT_MAX)
                    $display("unexpected digest transfer: word %h index %0d last %0b",
                             o_digest_word, o_word_index, o_last_word);
            end else begin
                exp_w = digest_q.pop_front();
                if (o_digest_word !== exp_w.word || o_word_index !== exp_w.idx ||
                    o_last_word !== exp_w.last) begin
                    n_faults++;
                    if (n_faults <= REPORT_MAX)
                        $display("digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                                 exp_w.word, exp_w.idx, exp_w.last,
                                 o_digest_word, o_word_index, o_last_word);
                end
            end
        end
        if (in_ok) begin
            if (i_req_type == REQ_FINISH)
                close_message();
            else
                absorb_byte(i_data_byte);
            void'(byte_stream_q.pop_front());
            n_in_done++;
        end
        // watchdog: any transfer on either side counts as progress
        if (!i_rst_n || in_ok || out_ok)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned n_msgs;
        int          len;
        n_msgs = 0;
        restart_hash();

        // empty message, twice in a row: state must be back to initial
        push_item(REQ_FINISH, 8'h00);
        push_item(REQ_FINISH, 8'hFF);
        // "abc"
        push_item(REQ_DATA, 8'h61);
        push_item(REQ_DATA, 8'h62);
        push_item(REQ_DATA, 8'h63);
        push_item(REQ_FINISH, 8'h00);
        // byte extremes and alternating bit patterns
        push_item(REQ_DATA, 8'h00);
        push_item(REQ_DATA, 8'hFF);
        push_item(REQ_DATA, 8'h55);
        push_item(REQ_DATA, 8'hAA);
        push_item(REQ_DATA, 8'h01);
        push_item(REQ_DATA, 8'h80);
        push_item(REQ_FINISH, 8'hAA);
        // single byte message
        push_item(REQ_DATA, 8'hFF);
        push_item(REQ_FINISH, 8'h55);

        // random messages, a quarter of them at the padding boundaries;
        // the 61-bit count wrap needs 2^61 bytes and is out of reach here
        while (byte_stream_q.size() < MIN_ITEMS || n_msgs < MIN_MESSAGES) begin
            if ($urandom_range(0, 3) == 0)
                len = tail_lens[$urandom_range(0, 9)];
            else
                len = $urandom_range(0, 20);
            push_message(len);
            n_msgs++;
        end
        n_items_total = byte_stream_q.size();

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_stream_q.size() != 0)
            @(posedge i_clk);
        while (digest_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_faults == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sha1_message_digest.f @@
rtl/sha1md_pkg.sv
rtl/sha1md_datapath.sv
rtl/sha1md_ctrl.sv
rtl/sha1_message_digest.sv
test/tb_top.sv
